@@ rtl/core/qsfm_pkg.sv @@
package qsfm_pkg;

  localparam int NUM_MOTORS          = 4;
  localparam int STATE_LEN           = 6;
  localparam int GAIN_FRAC_BITS_DEF  = 23;
  localparam int RATIO_BITS          = 20;
  localparam int QUO_W               = RATIO_BITS + 1;

  // Width of the B operand of the shared multiplier (covers the throttle
  // numerator and both reciprocals).
  localparam int B_W                 = 25;
  localparam int TNUM_W              = 24;

  // Division by 127 done as multiplication by a rounded-up reciprocal.
  localparam logic [B_W-1:0] REF_RECIP = B_W'(528417);
  localparam int             REF_SHIFT = 26;
  localparam logic [B_W-1:0] OUT_RECIP = B_W'(8454661);
  localparam int             OUT_SHIFT = 30;
  localparam logic [23:0]    SAT_LIMIT = 24'd4161536;
  localparam logic [14:0]    MOTOR_MAX = 15'd32767;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_HOVER   = 2'd1;
  localparam logic [1:0] CFG_SPAN    = 2'd2;
  localparam logic [1:0] CFG_TILT    = 2'd3;

  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [14:0] HOVER_RST   = 15'd8166;
  localparam logic [14:0] SPAN_RST    = 15'd8192;
  localparam logic [10:0] TILT_RST    = 11'd240;

  // Gain table in millionths, row per motor, column per state element.
  localparam int GAIN_MICRO [NUM_MOTORS][STATE_LEN] = '{
    '{  12936, -10663, -16771,  1856, -1532, -1287 },
    '{ -12936, -10663,  16771, -1856, -1532,  1287 },
    '{  12936,  10663,  16771,  1856,  1532,  1287 },
    '{ -12936,  10663, -16771, -1856,  1532, -1287 }
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_REF,
    S_MAC,
    S_TNUM,
    S_MIN,
    S_MAX,
    S_DIV,
    S_SCALE,
    S_OUT
  } seq_state_t;

  // Rounds a gain given in millionths to the fixed-point format, half away
  // from zero.
  function automatic longint gain_fixed(input int micro, input int frac);
    longint mag;
    longint q;
    mag = (micro < 0) ? -longint'(micro) : longint'(micro);
    q   = ((mag <<< frac) + 64'sd500000) / 64'sd1000000;
    return (micro < 0) ? -q : q;
  endfunction

endpackage

@@ rtl/core/quadrotor_state_feedback_mixer.sv @@
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tdata: IMU, commands, tick; s_tuser: packet_valid
// m_*       out        m_tvalid/m_tready   m_tdata: four motor values; m_tuser: motors_off
// cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// An item's result is worked out with the shared multiplier, which carries all 24
// multiply-accumulates, and, when the motors run and the effort is not flat, with
// the bit-serial divider (21 steps per motor). Synchronous reset restores the
// configuration registers and held state. The block is not ready while an item is
// in work; a finished result waits in the output register while the next item is
// taken.
module quadrotor_state_feedback_mixer
  import qsfm_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] now_tick, [63:32] packet_timestamp, [71:64] command_pitch,
  // [79:72] command_roll, [87:80] command_throttle, [101:88] heading,
  // [115:102] angle_one, [129:116] angle_two, [145:130] rate_x,
  // [161:146] rate_y, [177:162] rate_z, [183:178] zero
  input  logic [183:0] s_tdata,
  // [0] packet_valid
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [14:0] motor_front_right, [29:15] motor_front_left,
  // [44:30] motor_rear_left, [59:45] motor_rear_right, [63:60] zero
  output logic [63:0]  m_tdata,
  // [0] motors_off
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // Gain width follows from the largest gain magnitude, which is below 1/32.
  localparam int GW = GAIN_FRAC_BITS - 4;
  localparam int AW = (GW > 23) ? GW : 23;
  localparam int PW = AW + B_W;
  // Motor effort width: gain times an 18-bit error, summed six times.
  localparam int UW = GAIN_FRAC_BITS + 17;

  // Configuration registers.
  logic [15:0] command_timeout;
  logic [14:0] hover_throttle;
  logic [14:0] throttle_span;
  logic [10:0] max_tilt;

  // Held state.
  logic signed [15:0] held_angle [2];
  logic signed [15:0] held_rate  [3];
  logic signed [7:0]  held_pitch;
  logic signed [7:0]  held_roll;
  logic signed [7:0]  held_thr;
  logic [31:0]        held_time;
  logic [31:0]        now_reg;

  seq_state_t state;
  seq_state_t state_next;

  logic [1:0] ph;
  logic       ref_j;
  logic [1:0] k;
  logic [2:0] i;
  logic [4:0] div_cnt;

  logic signed [AW-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic               ref_neg;
  logic [17:0]        ref_mag;
  logic signed [12:0] ref_val [2];
  logic signed [UW-1:0] acc;
  logic signed [UW-1:0] u [NUM_MOTORS];
  logic signed [UW-1:0] mn;
  logic [UW-1:0]      shifted [NUM_MOTORS];
  logic [UW-1:0]      umax;
  logic [TNUM_W-1:0]  tnum;
  logic               off;
  logic [UW-1:0]      rem;
  logic [QUO_W-1:0]   quo;
  logic               sat;
  logic [21:0]        fm;
  logic [14:0]        motor [NUM_MOTORS];

  logic signed [GW-1:0] gain_tab [NUM_MOTORS][STATE_LEN];

  for (genvar gk = 0; gk < NUM_MOTORS; gk++) begin : g_row
    for (genvar gi = 0; gi < STATE_LEN; gi++) begin : g_col
      assign gain_tab[gk][gi] = GW'(gain_fixed(GAIN_MICRO[gk][gi], GAIN_FRAC_BITS));
    end
  end

  // Input field views.
  logic signed [7:0]  in_pitch, in_roll, in_thr;
  logic signed [13:0] in_head, in_a1, in_a2;
  logic signed [15:0] in_rx, in_ry, in_rz;
  assign in_pitch = s_tdata[71:64];
  assign in_roll  = s_tdata[79:72];
  assign in_thr   = s_tdata[87:80];
  assign in_head  = s_tdata[101:88];
  assign in_a1    = s_tdata[115:102];
  assign in_a2    = s_tdata[129:116];
  assign in_rx    = s_tdata[145:130];
  assign in_ry    = s_tdata[161:146];
  assign in_rz    = s_tdata[177:162];

  // Nothing is taken while reset is applied.
  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;

  // Negation saturating the full-scale negative rate.
  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  // Control error r - x for the current column.
  logic signed [17:0] diff;
  always_comb begin
    case (i)
      3'd1:    diff = 18'(ref_val[0]) - 18'(held_angle[0]);
      3'd2:    diff = 18'(ref_val[1]) - 18'(held_angle[1]);
      3'd3:    diff = -18'(held_rate[0]);
      3'd4:    diff = -18'(held_rate[1]);
      3'd5:    diff = -18'(held_rate[2]);
      default: diff = '0;
    endcase
  end

  // Minimum of the efforts, clamped so it is never positive.
  logic signed [UW-1:0] min01, min23, min_all;
  assign min01   = (u[1] < u[0]) ? u[1] : u[0];
  assign min23   = (u[3] < u[2]) ? u[3] : u[2];
  assign min_all = (min23 < min01) ? min23 : min01;

  // Shifted efforts and their maximum.
  logic [UW-1:0] sh_c [NUM_MOTORS];
  logic [UW-1:0] max01, max23, umax_c;
  always_comb begin
    for (int n = 0; n < NUM_MOTORS; n++) begin
      sh_c[n] = UW'((UW+1)'(u[n]) - (UW+1)'(mn));
    end
  end
  assign max01  = (sh_c[1] > sh_c[0]) ? sh_c[1] : sh_c[0];
  assign max23  = (sh_c[3] > sh_c[2]) ? sh_c[3] : sh_c[2];
  assign umax_c = (max23 > max01) ? max23 : max01;

  // One restoring division step.
  logic [UW:0]   cand;
  logic          ge;
  logic [UW-1:0] rem_step;
  assign cand     = (div_cnt == 5'd0) ? {1'b0, shifted[k]} : {rem, 1'b0};
  assign ge       = cand >= {1'b0, umax};
  assign rem_step = ge ? UW'(cand - {1'b0, umax}) : UW'(cand);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_REF;
      S_REF:   if (ph == 2'd3 && ref_j) state_next = S_MAC;
      S_MAC:   if (ph[0] && i == 3'd5 && k == 2'd3) state_next = S_TNUM;
      S_TNUM:  if (ph[0]) state_next = S_MIN;
      S_MIN:   state_next = S_MAX;
      S_MAX:   state_next = (off || umax_c == '0) ? S_OUT : S_DIV;
      S_DIV:   if (div_cnt == 5'(RATIO_BITS)) state_next = S_SCALE;
      S_SCALE: if (ph == 2'd3) state_next = (k == 2'd3) ? S_OUT : S_DIV;
      S_OUT:   if (out_free) state_next = S_IDLE;
    endcase
  end

  // Operands of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_REF: begin
        if (ph == 2'd0) begin
          mul_a = AW'({1'b0, max_tilt});
          mul_b = B_W'(ref_j ? held_roll : held_pitch);
        end else if (ph == 2'd2) begin
          mul_a = AW'({1'b0, ref_mag});
          mul_b = REF_RECIP;
        end
      end
      S_MAC: begin
        mul_a = AW'(gain_tab[k][i]);
        mul_b = B_W'(diff);
      end
      S_TNUM: begin
        mul_a = AW'({1'b0, throttle_span});
        mul_b = B_W'(held_thr);
      end
      S_SCALE: begin
        if (ph == 2'd0) begin
          mul_a = AW'({1'b0, quo});
          mul_b = B_W'({1'b0, tnum});
        end else if (ph == 2'd2) begin
          mul_a = AW'({1'b0, fm});
          mul_b = OUT_RECIP;
        end
      end
      default: ;
    endcase
  end

  qsfm_mult #(.AW(AW), .BW(B_W)) u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      command_timeout <= TIMEOUT_RST;
      hover_throttle  <= HOVER_RST;
      throttle_span   <= SPAN_RST;
      max_tilt        <= TILT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT: command_timeout <= cfg_data;
        CFG_HOVER:   hover_throttle  <= cfg_data[14:0];
        CFG_SPAN:    throttle_span   <= cfg_data[14:0];
        CFG_TILT:    max_tilt        <= cfg_data[10:0];
      endcase
    end
  end

  // Held state, captured as an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_angle <= '{default: '0};
      held_rate  <= '{default: '0};
      held_pitch <= '0;
      held_roll  <= '0;
      held_thr   <= '0;
      held_time  <= '0;
    end else if (s_tvalid && s_tready) begin
      if (!(in_head == '0 && in_a1 == '0 && in_a2 == '0)) begin
        held_angle[0] <= 16'(in_a1);
        held_angle[1] <= 16'(in_a2);
      end
      if (!(in_rx == '0 && in_ry == '0 && in_rz == '0)) begin
        held_rate[0] <= in_rz;
        held_rate[1] <= neg_sat(in_ry);
        held_rate[2] <= neg_sat(in_rx);
      end
      if (s_tuser) begin
        held_pitch <= in_pitch;
        held_roll  <= in_roll;
        held_thr   <= in_thr;
        held_time  <= s_tdata[63:32];
      end
    end
  end

  // Sequencer counters and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ph      <= '0;
      ref_j   <= 1'b0;
      k       <= '0;
      i       <= '0;
      div_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          ph      <= '0;
          ref_j   <= 1'b0;
          k       <= '0;
          i       <= '0;
          div_cnt <= '0;
          if (s_tvalid) begin
            now_reg <= s_tdata[31:0];
            acc     <= '0;
          end
        end
        S_REF: begin
          ph <= ph + 2'd1;
          if (ph == 2'd1) begin
            ref_neg <= prod[18];
            ref_mag <= prod[18] ? 18'(-prod[18:0]) : prod[17:0];
          end else if (ph == 2'd3) begin
            ref_val[ref_j] <= ref_neg ? -prod[REF_SHIFT+12:REF_SHIFT]
                                      : prod[REF_SHIFT+12:REF_SHIFT];
            ref_j <= ~ref_j;
          end
        end
        S_MAC: begin
          // The phase toggles, so it is back at zero after each product.
          ph <= {1'b0, ~ph[0]};
          if (ph[0]) begin
            if (i == 3'd5) begin
              u[k] <= acc + UW'(prod);
              acc  <= '0;
              i    <= '0;
              k    <= k + 2'd1;
            end else begin
              acc <= acc + UW'(prod);
              i   <= i + 3'd1;
            end
          end
        end
        S_TNUM: begin
          ph <= {1'b0, ~ph[0]};
          if (ph[0]) begin
            tnum <= TNUM_W'(prod) + TNUM_W'({hover_throttle, 7'd0})
                    - TNUM_W'(hover_throttle);
          end
        end
        S_MIN: begin
          mn  <= (min_all > 0) ? '0 : min_all;
          off <= ((now_reg - held_time) > 32'(command_timeout)) ||
                 held_thr[7] || (held_thr == '0);
        end
        S_MAX: begin
          shifted <= sh_c;
          umax    <= umax_c;
          div_cnt <= '0;
          motor   <= '{default: '0};
        end
        S_DIV: begin
          rem     <= rem_step;
          quo     <= {quo[QUO_W-2:0], ge};
          div_cnt <= div_cnt + 5'd1;
          ph      <= '0;
        end
        S_SCALE: begin
          ph <= ph + 2'd1;
          if (ph == 2'd1) begin
            sat <= prod[RATIO_BITS+23:RATIO_BITS] >= SAT_LIMIT;
            fm  <= prod[RATIO_BITS+21:RATIO_BITS];
          end else if (ph == 2'd3) begin
            motor[k] <= sat ? MOTOR_MAX : prod[OUT_SHIFT+14:OUT_SHIFT];
            k        <= k + 2'd1;
            div_cnt  <= '0;
          end
        end
        S_OUT: ;
      endcase
    end
  end

  // Output register: loaded when the result is complete and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {4'd0, motor[3], motor[2], motor[1], motor[0]};
      m_tuser  <= off;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // A result flagged as motors off carries zero motor values.
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[59:0] == '0))
    else $error("motors_off result with non-zero motor values");

  // Accepting an item makes the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while busy");

  // The divider never runs beyond the quotient width.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt <= 5'(RATIO_BITS)))
    else $error("divider step count out of range");

  // The output register is only loaded from the result state.
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_OUT))
    else $error("result produced outside the result state");

endmodule

@@ rtl/core/qsfm_mult.sv @@
module qsfm_mult
  import qsfm_pkg::*;
#(
  parameter int AW = 23,
  parameter int BW = B_W
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  // Registered signed product.
  always_ff @(posedge clk) begin
    p <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule

@@ bench/quadrotor_state_feedback_mixer_tb.sv @@
`timescale 1ns / 1ps

// Bench for the quadrotor state-feedback mixer.
//
// A directed table is run first. Then five configuration phases of random
// control ticks follow. The register settings include the extremes and values
// beyond the stated range. Every accepted item is fed to a predictor that
// keeps its own held angles, rates, commands and packet stamp. The motor
// values it expects are queued, and each result leaving the block is
// compared with the oldest entry, field by field.
module quadrotor_state_feedback_mixer_tb;
  import qsfm_pkg::*;

  localparam int RATIO_SHIFT = 20;
  localparam int GAIN_SHIFT  = 23;
  // This pause leaves room for the slow path to finish.
  localparam int SETTLE_CYCLES = 250;
  localparam int ITEMS_PER_PHASE = 320;

  typedef struct packed {
    logic [31:0]        now_tick;
    logic               packet_valid;
    logic [31:0]        packet_timestamp;
    logic signed [7:0]  cmd_pitch;
    logic signed [7:0]  cmd_roll;
    logic signed [7:0]  cmd_throttle;
    logic signed [13:0] heading;
    logic signed [13:0] angle_one;
    logic signed [13:0] angle_two;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } tick_t;

  typedef struct packed {
    logic [14:0] front_right;
    logic [14:0] front_left;
    logic [14:0] rear_left;
    logic [14:0] rear_right;
    logic        motors_off;
  } motor_set_t;

  // One row of the directed table. Where known is set, every motor value
  // is plainly zero, and the row states motors_off directly in known_off.
  typedef struct packed {
    tick_t tick;
    logic  known;
    logic  known_off;
  } step_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [183:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = CFG_TIMEOUT;
  logic [15:0]  cfg_data = '0;

  quadrotor_state_feedback_mixer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // These are the predictor's copies of the registers and of the held state.
  logic [15:0]        pr_timeout;
  logic [14:0]        pr_hover;
  logic [14:0]        pr_span;
  logic [10:0]        pr_tilt;
  logic signed [15:0] kept_angle [2];
  logic signed [15:0] kept_rate [3];
  logic signed [7:0]  kept_pitch, kept_roll, kept_throttle;
  logic [31:0]        kept_stamp;

  longint gain_q [4][6];
  // Gains in millionths, one row per motor.
  const int gain_millionths [4][6] = '{
    '{  12936, -10663, -16771,  1856, -1532, -1287 },
    '{ -12936, -10663,  16771, -1856, -1532,  1287 },
    '{  12936,  10663,  16771,  1856,  1532,  1287 },
    '{ -12936,  10663, -16771, -1856,  1532, -1287 }
  };

  motor_set_t motor_plan [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int off_seen = 0;
  int settings_run = 0;
  bit steady = 1'b0;  // When set, neither side stalls.
  int rx_wait = 0;

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [15:0] negate_clamped(input logic signed [15:0] v);
    longint n;
    n = -longint'(v);
    if (n > 32767) n = 32767;
    return 16'(n);
  endfunction

  // This works out the motor set for one tick and advances the held state.
  function automatic motor_set_t mix_tick(input tick_t t);
    longint x [6];
    longint ref_ang [6];
    longint effort [4];
    longint lo, hi, acc;
    longint unsigned lifted [4];
    longint unsigned peak, tnum, ratio, m;
    logic [31:0] age;
    logic [14:0] mv [4];
    motor_set_t res;
    if (!(t.heading == 0 && t.angle_one == 0 && t.angle_two == 0)) begin
      kept_angle[0] = 16'(t.angle_one);
      kept_angle[1] = 16'(t.angle_two);
    end
    if (!(t.rate_x == 0 && t.rate_y == 0 && t.rate_z == 0)) begin
      kept_rate[0] = t.rate_z;
      kept_rate[1] = negate_clamped(t.rate_y);
      kept_rate[2] = negate_clamped(t.rate_x);
    end
    if (t.packet_valid) begin
      kept_pitch    = t.cmd_pitch;
      kept_roll     = t.cmd_roll;
      kept_throttle = t.cmd_throttle;
      kept_stamp    = t.packet_timestamp;
    end
    x = '{0, kept_angle[0], kept_angle[1], kept_rate[0], kept_rate[1], kept_rate[2]};
    ref_ang = '{0, 0, 0, 0, 0, 0};
    ref_ang[1] = (longint'(pr_tilt) * longint'(kept_pitch)) / 127;
    ref_ang[2] = (longint'(pr_tilt) * longint'(kept_roll)) / 127;
    for (int k = 0; k < 4; k++) begin
      acc = 0;
      for (int i = 0; i < 6; i++) acc += gain_q[k][i] * (ref_ang[i] - x[i]);
      effort[k] = acc;
    end
    lo = effort[0];
    for (int k = 1; k < 4; k++) if (effort[k] < lo) lo = effort[k];
    if (lo > 0) lo = 0;
    hi = 0;
    for (int k = 0; k < 4; k++) begin
      lifted[k] = longint'(effort[k] - lo);
      if (effort[k] - lo > hi) hi = effort[k] - lo;
    end
    peak = hi;
    age = t.now_tick - kept_stamp;
    res = '0;
    res.motors_off = (age > 32'(pr_timeout)) || (kept_throttle <= 0);
    if (res.motors_off || peak == 0) return res;
    tnum = longint'(pr_hover) * 127 + longint'(pr_span) * longint'(kept_throttle);
    for (int k = 0; k < 4; k++) begin
      ratio = (lifted[k] << RATIO_SHIFT) / peak;
      m = (ratio * tnum) / (longint'(127) << RATIO_SHIFT);
      mv[k] = (m > 32767) ? 15'd32767 : 15'(m);
    end
    res.front_right = mv[0];
    res.front_left  = mv[1];
    res.rear_left   = mv[2];
    res.rear_right  = mv[3];
    return res;
  endfunction

  // This hands one tick to the block and returns at the edge that accepts it.
  task automatic send_tick(input tick_t t);
    s_tvalid <= 1'b1;
    s_tuser  <= t.packet_valid;
    s_tdata  <= {6'b0, t.rate_z, t.rate_y, t.rate_x, t.angle_two, t.angle_one, t.heading,
                 t.cmd_throttle, t.cmd_roll, t.cmd_pitch, t.packet_timestamp, t.now_tick};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The write stays valid on return; the caller drops cfg_valid after its last write.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TIMEOUT: pr_timeout = value;
      CFG_HOVER:   pr_hover   = value[14:0];
      CFG_SPAN:    pr_span    = value[14:0];
      CFG_TILT:    pr_tilt    = value[10:0];
      default: ;
    endcase
  endtask

  // Registers change only once the block has drained.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (motor_plan.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_all(input logic [15:0] tmo, input logic [15:0] hov,
                         input logic [15:0] spn, input logic [15:0] tlt);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_HOVER, hov);
    write_reg(CFG_SPAN, spn);
    write_reg(CFG_TILT, tlt);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // Random ticks mostly form a live command stream: the tick count runs on,
  // and packet stamps lie close behind it. A few stale or wild stamps and
  // bad IMU readings are mixed in.
  function automatic tick_t random_tick(inout logic [31:0] clock_now);
    tick_t t;
    int pick;
    clock_now += $urandom_range(1, 3);
    if ($urandom_range(0, 49) == 0) clock_now = $urandom;
    t.now_tick = clock_now;
    t.packet_valid = ($urandom_range(0, 9) < 8);
    pick = $urandom_range(0, 19);
    if (pick < 10) t.packet_timestamp = clock_now;
    else if (pick < 19) t.packet_timestamp = clock_now - $urandom_range(0, 200);
    else t.packet_timestamp = $urandom;
    t.cmd_pitch = 8'($urandom);
    t.cmd_roll  = 8'($urandom);
    t.cmd_throttle = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 127)) : 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      t.heading = '0;
      t.angle_one = '0;
      t.angle_two = '0;
    end else begin
      t.heading   = 14'(int'($urandom_range(0, 11520)) - 5760);
      t.angle_one = 14'(int'($urandom_range(0, 11520)) - 5760);
      t.angle_two = 14'(int'($urandom_range(0, 11520)) - 5760);
    end
    if ($urandom_range(0, 9) == 0) begin
      t.rate_x = '0;
      t.rate_y = '0;
      t.rate_z = '0;
    end else begin
      t.rate_x = 16'($urandom);
      t.rate_y = 16'($urandom);
      t.rate_z = 16'($urandom);
    end
    return t;
  endfunction

  // The directed ticks run under the reset settings (timeout 100). They
  // cover the reset state, a flat effort, a heading-only reading and the
  // extremes of every field. They also take in the full-scale negated rate,
  // the timeout edge, throttle at zero and negative, and stamp wrap-around.
  const step_row_t opening_rows [15] = '{
    '{'{32'd5, 1'b0, 32'd0, 8'sd0, 8'sd0, 8'sd0, 14'sd0, 14'sd0, 14'sd0,
        16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b1},
    '{'{32'd10, 1'b1, 32'd10, 8'sd0, 8'sd0, 8'sd50, 14'sd0, 14'sd0, 14'sd0,
        16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
    '{'{32'd11, 1'b0, 32'd0, 8'sd0, 8'sd0, 8'sd0, 14'sd100, 14'sd0, 14'sd0,
        16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
    '{'{32'd12, 1'b1, 32'd12, 8'sd127, -8'sd128, 8'sd127, 14'sd5760, -14'sd5760,
        14'sd5760, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b0, 1'b0},
    '{'{32'd13, 1'b0, 32'd0, 8'sd0, 8'sd0, 8'sd0, 14'sd0, 14'sd0, 14'sd0,
        16'sd0, 16'sd0, 16'sd0}, 1'b0, 1'b0},
    '{'{32'd14, 1'b0, 32'd0, 8'sd0, 8'sd0, 8'sd0, -14'sd5760, 14'sd5760, -14'sd5760,
        16'sd0, 16'sd0, -16'sd32768}, 1'b0, 1'b0},
    '{'{32'd112, 1'b0, 32'd0, 8'sd0, 8'sd0, 8'sd0, 14'sd3, 14'sd40, -14'sd40,
        16'sd77, -16'sd5, 16'sd9}, 1'b0, 1'b0},
    '{'{32'd113, 1'b0, 32'd0, 8'sd0, 8'sd0, 8'sd0, 14'sd3, 14'sd40, -14'sd40,
        16'sd77, -16'sd5, 16'sd9}, 1'b1, 1'b1},
    '{'{32'd200, 1'b1, 32'd199, 8'sd10, 8'sd10, 8'sd0, 14'sd1, 14'sd1, 14'sd1,
        16'sd1, 16'sd1, 16'sd1}, 1'b1, 1'b1},
    '{'{32'd201, 1'b1, 32'd201, 8'sd10, 8'sd10, -8'sd128, 14'sd1, 14'sd1, 14'sd1,
        16'sd1, 16'sd1, 16'sd1}, 1'b1, 1'b1},
    '{'{32'd202, 1'b1, 32'd202, -8'sd128, 8'sd127, 8'sd1, 14'sd0, 14'sd0, 14'sd0,
        16'sd1, -16'sd1, 16'sd1}, 1'b0, 1'b0},
    '{'{32'd0, 1'b1, 32'hFFFF_FFF0, 8'sd33, -8'sd70, 8'sd64, 14'sd200, -14'sd300,
        14'sd150, 16'sd1000, -16'sd2000, 16'sd3000}, 1'b0, 1'b0},
    '{'{32'hFFFF_FFFF, 1'b1, 32'd0, 8'sd33, -8'sd70, 8'sd64, 14'sd0, 14'sd0, 14'sd0,
        16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b1},
    '{'{32'd7, 1'b1, 32'h8000_0000, 8'sd1, 8'sd1, 8'sd100, 14'sd0, 14'sd0, 14'sd0,
        16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b1},
    '{'{32'd100, 1'b1, 32'd100, 8'sd0, 8'sd0, 8'sd127, 14'sd5, 14'sd16, -14'sd32,
        16'sd100, -16'sd200, 16'sd300}, 1'b0, 1'b0}
  };

  initial begin
    motor_set_t want;
    logic [31:0] clock_now;
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 6; i++) begin
        longint mag;
        mag = (gain_millionths[k][i] < 0) ? -longint'(gain_millionths[k][i])
                                           : longint'(gain_millionths[k][i]);
        mag = ((mag << GAIN_SHIFT) + 500000) / 1000000;
        gain_q[k][i] = (gain_millionths[k][i] < 0) ? -mag : mag;
      end
    pr_timeout = TIMEOUT_RST;
    pr_hover = HOVER_RST;
    pr_span = SPAN_RST;
    pr_tilt = TILT_RST;
    kept_angle = '{0, 0};
    kept_rate = '{0, 0, 0};
    kept_pitch = 0;
    kept_roll = 0;
    kept_throttle = 0;
    kept_stamp = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_rows[r]) begin
      send_tick(opening_rows[r].tick);
      want = mix_tick(opening_rows[r].tick);
      if (opening_rows[r].known) begin
        want = '0;
        want.motors_off = opening_rows[r].known_off;
      end
      motor_plan.push_back(want);
      pause_sender();
    end

    clock_now = $urandom;
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: set_all(16'd100, 16'd8166, 16'd8192, 16'd240);
        1: set_all(16'hFFFF, 16'd0, 16'd32767, 16'd1440);
        2: set_all(16'd0, 16'd32767, 16'd0, 16'd0);
        3: set_all(16'd50, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // beyond the stated range
        default: set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      steady = (phase == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        tick_t t;
        t = random_tick(clock_now);
        send_tick(t);
        motor_plan.push_back(mix_tick(t));
        pause_sender();
      end
    end

    drain();
    $display("Ran %0d ticks under %0d register settings, with %0d results checked",
             items_sent, settings_run, results_seen);
    $display("of which %0d had the motors forced off.", off_seen);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Each result is checked against the oldest prediction. After every
  // result the receiver stalls for a random count of cycles, possibly none.
  always @(posedge clk) begin
    motor_set_t want;
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser) off_seen++;
      if (motor_plan.size() == 0) begin
        note_mismatch("result with nothing pending", m_tdata, 0);
      end else begin
        want = motor_plan.pop_front();
        if (m_tdata[14:0] != want.front_right)
          note_mismatch("front right", m_tdata[14:0], want.front_right);
        if (m_tdata[29:15] != want.front_left)
          note_mismatch("front left", m_tdata[29:15], want.front_left);
        if (m_tdata[44:30] != want.rear_left)
          note_mismatch("rear left", m_tdata[44:30], want.rear_left);
        if (m_tdata[59:45] != want.rear_right)
          note_mismatch("rear right", m_tdata[59:45], want.rear_right);
        if (m_tdata[63:60] != 4'd0)
          note_mismatch("padding bits", m_tdata[63:60], 0);
        if (m_tuser != want.motors_off)
          note_mismatch("motors off", m_tuser, want.motors_off);
      end
      gap = steady ? 0 : $urandom_range(0, 5);
      rx_wait <= gap;
      if (gap != 0) m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      if (rx_wait == 1) m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results still pending", motor_plan.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
